>>> rtl/thermistor_adc_to_temperature_top_defines.svh
// assertion macros used by the thermistor converter rtl
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_TOP_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TATC_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TATC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tatc_pkg.sv
// types and constants of the thermistor temperature converter
`timescale 1ns / 1ps

package tatc_pkg;

    // field and datapath widths
    localparam int BETA_W   = 14;
    localparam int TEMP_W   = 14;
    localparam int LG_N_W   = 16;
    localparam int LG_E_W   = 4;
    localparam int LG_M_W   = 31;
    localparam int LG_F_W   = 24;
    localparam int LG_STEPS = 24;
    localparam int LOG_W    = LG_E_W + LG_F_W;
    localparam int LN_W     = 28;
    localparam int DM_W     = 31;
    localparam int QUO_W    = 54;
    localparam int QC_W     = 41;
    localparam int BT_W     = 30;
    localparam int T_W      = 42;
    localparam int V_W      = 48;

    // ln 2 in q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // kelvin offsets in tenths, in q.16: 273.15 for celsius, 459.67 for fahrenheit
    localparam logic signed [V_W-1:0] KELVIN_C = 48'sd179011584;
    localparam logic signed [V_W-1:0] KELVIN_F = 48'sd301249331;

    // output limits and the degenerate-code results
    localparam logic signed [V_W-1:0]    OUT_MIN_V  = -48'sd5000;
    localparam logic signed [V_W-1:0]    OUT_MAX_V  = 48'sd6000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -14'sd5000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 14'sd6000;
    localparam logic signed [TEMP_W-1:0] TEMP_INV_C = -14'sd2731;
    localparam logic signed [TEMP_W-1:0] TEMP_INV_F = -14'sd4597;

    localparam logic [BETA_W-1:0] BETA_RESET = 14'd4275;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_USE_CELSIUS = 1'b0,
        REG_BETA_VALUE  = 1'b1
    } tatc_reg_t;

    // per-stage control
    typedef struct packed {
        logic valid;
        logic inv;
    } tatc_ctl_t;

    // one log2 lane: exponent, q1.30 mantissa, fraction bits so far
    typedef struct packed {
        logic [LG_E_W-1:0] e;
        logic [LG_M_W-1:0] m;
        logic [LG_F_W-1:0] frac;
    } tatc_lg_t;

    // divider state handed from cell to cell
    typedef struct packed {
        logic [DM_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
        logic [DM_W-1:0]  dm;
        logic             dneg;
        logic             dz;
    } tatc_div_t;

endpackage

>>> rtl/thermistor_adc_to_temperature_top.sv
// top level of the ntc thermistor adc to temperature converter
//
// Input channel adc_valid/adc_stall carries one adc_code per beat; output
// channel temp_valid/temp_stall carries temp_tenths (signed tenths of a
// degree, saturated to -5000..6000) and the invalid flag for codes 0 and
// full scale. Configuration is a plain write port: cfg_index 0 selects
// use_celsius, index 1 the beta constant; writes take effect at once. The
// user must see that writes are made while no beat is in flight; the block
// does not enforce it. From the accepting edge, a beat passes the front
// stage, 24 log2 squaring cells, three ln/denominator stages, 54 restoring
// division cells, two scaling stages and the output register in turn.
// Throughput is one beat per clock while adc_stall is low; the 54-cell
// divider chain and the log2 cell row set the depth, one item per cell.
// A one-entry skid behind the output register absorbs a beat when the
// receiver stalls; adc_stall rises only while that skid is full, and
// the whole chain then holds until the output register drains.
// Reset clears all valid state, sets Fahrenheit and beta 4275; the beta
// reciprocal is registered and settles again after reset or a beta write.
`timescale 1ns / 1ps
`include "thermistor_adc_to_temperature_top_defines.svh"

module thermistor_adc_to_temperature_top
    import tatc_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [BETA_W-1:0]        cfg_data,
    input  logic                     adc_valid,
    output logic                     adc_stall,
    input  logic [ADC_BITS-1:0]      adc_code,
    output logic                     temp_valid,
    input  logic                     temp_stall,
    output logic signed [TEMP_W-1:0] temp_tenths,
    output logic                     invalid
);

    localparam logic [ADC_BITS-1:0] FULL_CODE = '1;
    localparam logic [QUO_W-1:0]    T_CLAMP   = QUO_W'(1) << (QC_W - 1);

    // configuration registers
    logic              use_celsius_reg;
    logic [BETA_W-1:0] beta_reg;
    logic [BT_W-1:0]   bt;

    // pipeline signals
    logic      en;
    tatc_ctl_t fr_ctl_reg;
    tatc_lg_t  fr_a_reg;
    tatc_lg_t  fr_b_reg;
    tatc_ctl_t lg_ctl [0:LG_STEPS];
    tatc_lg_t  lg_a   [0:LG_STEPS];
    tatc_lg_t  lg_b   [0:LG_STEPS];

    tatc_ctl_t         l1_ctl_reg;
    logic [LOG_W-1:0]  l1_mag_reg;
    logic              l1_neg_reg;
    tatc_ctl_t         l2_ctl_reg;
    logic [LN_W-1:0]   l2_lnm_reg;
    logic              l2_neg_reg;
    tatc_ctl_t         l3_ctl_reg;
    tatc_div_t         l3_d_reg;

    tatc_ctl_t dv_ctl [0:QUO_W];
    tatc_div_t dv_d   [0:QUO_W];

    tatc_ctl_t               p1_ctl_reg;
    logic signed [T_W-1:0]   p1_t_reg;
    logic                    p1_dz_reg;
    tatc_ctl_t               p2_ctl_reg;
    logic signed [V_W-1:0]   p2_v_reg;
    logic                    p2_dz_reg;

    // output register and skid
    logic                     temp_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     invalid_reg;
    logic                     skid_full_reg;
    logic signed [TEMP_W-1:0] skid_temp_reg;
    logic                     skid_inv_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_celsius_reg <= 1'b0;
            beta_reg        <= BETA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_USE_CELSIUS: use_celsius_reg <= cfg_data[0];
                REG_BETA_VALUE:  beta_reg        <= cfg_data;
                default:         use_celsius_reg <= use_celsius_reg;
            endcase
        end
    end

    tatc_beta_recip u_recip (
        .clk  (clk),
        .beta (beta_reg),
        .bt   (bt)
    );

    // the chain moves whenever the skid has room
    assign en        = !skid_full_reg;
    assign adc_stall = skid_full_reg;

    // normalize n to a q1.30 mantissa with its top bit position
    function automatic tatc_lg_t lg_init(input logic [LG_N_W-1:0] n);
        logic [LG_E_W-1:0] e;
        logic [LG_M_W-1:0] ext;
        tatc_lg_t          r;
        e = '0;
        for (int i = 0; i < LG_N_W; i++)
        begin
            if (n[i])
            begin
                e = LG_E_W'(i);
            end
        end
        ext    = LG_M_W'(n);
        r.e    = e;
        r.m    = ext << (5'(LG_M_W - 1) - 5'(e));
        r.frac = '0;
        return r;
    endfunction

    // front stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_ctl_reg <= '0;
        end
        else if (en)
        begin
            fr_ctl_reg.valid <= adc_valid;
            fr_ctl_reg.inv   <= (adc_code == '0) || (adc_code == FULL_CODE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_a_reg <= lg_init(LG_N_W'(FULL_CODE - adc_code));
            fr_b_reg <= lg_init(LG_N_W'(adc_code));
        end
    end

    // log2 cell row
    assign lg_ctl[0] = fr_ctl_reg;
    assign lg_a[0]   = fr_a_reg;
    assign lg_b[0]   = fr_b_reg;

    for (genvar k = 0; k < LG_STEPS; k++)
    begin : g_log
        tatc_log_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (lg_ctl[k]),
            .a_in    (lg_a[k]),
            .b_in    (lg_b[k]),
            .ctl_out (lg_ctl[k+1]),
            .a_out   (lg_a[k+1]),
            .b_out   (lg_b[k+1])
        );
    end

    // ln ratio and denominator
    logic [LOG_W-1:0]      la;
    logic [LOG_W-1:0]      lb;
    logic signed [LOG_W:0] l2;
    logic [LOG_W:0]        l2_abs;
    logic [LOG_W+32:0]     ln_prod;
    logic signed [31:0]    d_sum;
    logic [31:0]           d_abs;
    tatc_div_t             d_first;

    always_comb
    begin
        la      = {lg_a[LG_STEPS].e, lg_a[LG_STEPS].frac};
        lb      = {lg_b[LG_STEPS].e, lg_b[LG_STEPS].frac};
        l2      = $signed({1'b0, la}) - $signed({1'b0, lb});
        l2_abs  = l2[LOG_W] ? -l2 : l2;
        ln_prod = (LOG_W+33)'(l1_mag_reg) * (LOG_W+33)'(LN2_Q32)
                  + ((LOG_W+33)'(1) << 31);
        if (l2_neg_reg)
        begin
            d_sum = $signed(32'(bt)) - $signed(32'(l2_lnm_reg));
        end
        else
        begin
            d_sum = $signed(32'(bt)) + $signed(32'(l2_lnm_reg));
        end
        d_abs        = d_sum[31] ? -d_sum : d_sum;
        d_first.rem  = '0;
        d_first.quo  = '0;
        d_first.dm   = d_abs[DM_W-1:0];
        d_first.dneg = d_sum[31];
        d_first.dz   = (d_sum == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_ctl_reg <= '0;
            l2_ctl_reg <= '0;
            l3_ctl_reg <= '0;
        end
        else if (en)
        begin
            l1_ctl_reg <= lg_ctl[LG_STEPS];
            l2_ctl_reg <= l1_ctl_reg;
            l3_ctl_reg <= l2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_mag_reg <= l2_abs[LOG_W-1:0];
            l1_neg_reg <= l2[LOG_W];
            l2_lnm_reg <= ln_prod[LN_W+31:32];
            l2_neg_reg <= l1_neg_reg;
            l3_d_reg   <= d_first;
        end
    end

    // division cell row: (beta << 40) / |d|
    assign dv_ctl[0] = l3_ctl_reg;
    assign dv_d[0]   = l3_d_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        logic dbit;
        if (k < BETA_W)
        begin : g_beta_bit
            assign dbit = beta_reg[BETA_W-1-k];
        end
        else
        begin : g_zero_bit
            assign dbit = 1'b0;
        end
        tatc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .dbit    (dbit),
            .ctl_in  (dv_ctl[k]),
            .d_in    (dv_d[k]),
            .ctl_out (dv_ctl[k+1]),
            .d_out   (dv_d[k+1])
        );
    end

    // clamp, sign, then scale to tenths
    logic [QC_W-1:0]         qc;
    logic signed [T_W-1:0]   t_mag;
    logic signed [T_W-1:0]   t_next;
    logic signed [V_W-1:0]   tv;
    logic signed [V_W-1:0]   v_next;

    always_comb
    begin
        qc    = (dv_d[QUO_W].quo > T_CLAMP) ? T_CLAMP[QC_W-1:0]
                                            : dv_d[QUO_W].quo[QC_W-1:0];
        t_mag = $signed(T_W'(qc));
        if (dv_ctl[QUO_W].inv)
        begin
            t_next = '0;
        end
        else if (dv_d[QUO_W].dneg)
        begin
            t_next = -t_mag;
        end
        else
        begin
            t_next = t_mag;
        end
        tv = V_W'(p1_t_reg);
        if (use_celsius_reg)
        begin
            v_next = (tv <<< 3) + (tv <<< 1) - KELVIN_C;
        end
        else
        begin
            v_next = (tv <<< 4) + (tv <<< 1) - KELVIN_F;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
            p2_ctl_reg <= '0;
        end
        else if (en)
        begin
            p1_ctl_reg <= dv_ctl[QUO_W];
            p2_ctl_reg <= p1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_t_reg  <= t_next;
            p1_dz_reg <= dv_d[QUO_W].dz;
            p2_v_reg  <= v_next;
            p2_dz_reg <= p1_dz_reg;
        end
    end

    // round half up and saturate
    logic signed [V_W-1:0]    v_rnd;
    logic signed [V_W-1:0]    v_sh;
    logic signed [TEMP_W-1:0] res_temp;

    always_comb
    begin
        v_rnd = p2_v_reg + V_W'(32768);
        v_sh  = v_rnd >>> 16;
        if (p2_dz_reg && !p2_ctl_reg.inv)
        begin
            res_temp = TEMP_MAX;
        end
        else if (v_sh < OUT_MIN_V)
        begin
            res_temp = TEMP_MIN;
        end
        else if (v_sh > OUT_MAX_V)
        begin
            res_temp = TEMP_MAX;
        end
        else
        begin
            res_temp = TEMP_W'(v_sh);
        end
    end

    // output register with one-entry skid
    logic                     temp_valid_next;
    logic                     skid_full_next;
    logic                     load_out;
    logic                     load_skid;

    always_comb
    begin
        load_out        = !temp_valid_reg || !temp_stall;
        load_skid       = !load_out && en && p2_ctl_reg.valid;
        temp_valid_next = temp_valid_reg;
        skid_full_next  = skid_full_reg;
        if (load_out)
        begin
            temp_valid_next = skid_full_reg || p2_ctl_reg.valid;
            skid_full_next  = 1'b0;
        end
        else if (load_skid)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_valid_reg <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else
        begin
            temp_valid_reg <= temp_valid_next;
            skid_full_reg  <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            temp_reg    <= skid_full_reg ? skid_temp_reg : res_temp;
            invalid_reg <= skid_full_reg ? skid_inv_reg : p2_ctl_reg.inv;
        end
        if (load_skid)
        begin
            skid_temp_reg <= res_temp;
            skid_inv_reg  <= p2_ctl_reg.inv;
        end
    end

    assign temp_valid  = temp_valid_reg;
    assign temp_tenths = temp_reg;
    assign invalid     = invalid_reg;

    // checks
    `TATC_ASSERT_HOLDS(a_skid_needs_out, skid_full_reg, temp_valid_reg,
        "skid holds a beat while the output register is empty")
    `TATC_ASSERT_HOLDS(a_out_range, temp_valid_reg,
        (temp_reg >= TEMP_MIN && temp_reg <= TEMP_MAX), "result outside saturation range")
    `TATC_ASSERT_HOLDS(a_invalid_value, temp_valid_reg && invalid_reg,
        (temp_reg == TEMP_INV_C || temp_reg == TEMP_INV_F), "degenerate code not at absolute zero")
    `TATC_ASSERT_NEXT(a_skid_drains, skid_full_reg && !temp_stall, !skid_full_reg,
        "skid not drained after output moved")

endmodule

>>> rtl/tatc_log_cell.sv
// one squaring step of the two log2 lanes
`timescale 1ns / 1ps

module tatc_log_cell
    import tatc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  tatc_ctl_t ctl_in,
    input  tatc_lg_t  a_in,
    input  tatc_lg_t  b_in,
    output tatc_ctl_t ctl_out,
    output tatc_lg_t  a_out,
    output tatc_lg_t  b_out
);

    tatc_ctl_t ctl_reg;
    tatc_lg_t  a_reg;
    tatc_lg_t  b_reg;
    tatc_lg_t  a_next;
    tatc_lg_t  b_next;

    // square the mantissa, renormalize, shift one fraction bit in
    function automatic tatc_lg_t lg_step(input tatc_lg_t x);
        logic [2*LG_M_W-1:0] sq;
        logic [LG_M_W:0]     s;
        tatc_lg_t            r;
        sq = (2*LG_M_W)'(x.m) * (2*LG_M_W)'(x.m);
        s  = sq[2*LG_M_W-1:LG_M_W-1];
        r  = x;
        if (s[LG_M_W])
        begin
            r.m    = s[LG_M_W:1];
            r.frac = {x.frac[LG_F_W-2:0], 1'b1};
        end
        else
        begin
            r.m    = s[LG_M_W-1:0];
            r.frac = {x.frac[LG_F_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        a_next = lg_step(a_in);
        b_next = lg_step(b_in);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // lane data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;

endmodule

>>> rtl/tatc_div_cell.sv
// one restoring-division step, one quotient bit
`timescale 1ns / 1ps

module tatc_div_cell
    import tatc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      dbit,
    input  tatc_ctl_t ctl_in,
    input  tatc_div_t d_in,
    output tatc_ctl_t ctl_out,
    output tatc_div_t d_out
);

    tatc_ctl_t   ctl_reg;
    tatc_div_t   d_reg;
    tatc_div_t   d_next;
    logic [DM_W:0] rem_sh;
    logic [DM_W:0] rem_sub;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        rem_sh  = {d_in.rem, dbit};
        rem_sub = rem_sh - {1'b0, d_in.dm};
        d_next  = d_in;
        if (rem_sh >= {1'b0, d_in.dm})
        begin
            d_next.rem = rem_sub[DM_W-1:0];
            d_next.quo = {d_in.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = rem_sh[DM_W-1:0];
            d_next.quo = {d_in.quo[QUO_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // divider data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;

endmodule

>>> rtl/tatc_beta_recip.sv
// beta / 298.15 in q6.24, rounded, from the beta register
`timescale 1ns / 1ps

module tatc_beta_recip
    import tatc_pkg::*;
(
    input  logic              clk,
    input  logic [BETA_W-1:0] beta,
    output logic [BT_W-1:0]   bt
);

    // 20 * 2^24 = 5963 * 56271 + 347, quotient by 5963 via 2^32 reciprocal
    localparam logic [16:0] Q_HI  = 17'd56271;
    localparam logic [8:0]  R_LO  = 9'd347;
    localparam logic [11:0] HALF  = 12'd2981;
    localparam logic [12:0] DIV   = 13'd5963;
    localparam logic [19:0] RECIP = 20'd720269;

    logic [BT_W-1:0] p1_reg;
    logic [22:0]     y_reg;
    logic [BT_W-1:0] p1b_reg;
    logic [22:0]     yb_reg;
    logic [9:0]      qe_reg;
    logic [BT_W-1:0] bt_reg;
    logic [42:0]     yq;
    logic [23:0]     qd;
    logic [23:0]     r;
    logic [BT_W-1:0] bt_next;

    assign yq = 43'(yb_reg) * 43'(RECIP);
    assign qd = 24'(qe_reg) * 24'(DIV);
    assign r  = 24'(y_reg) - qd;

    // correct the estimate by one step
    always_comb
    begin
        bt_next = p1_reg + BT_W'(qe_reg);
        if (r >= 24'(DIV))
        begin
            bt_next = bt_next + BT_W'(1);
        end
    end

    // three registered steps
    always_ff @(posedge clk)
    begin
        p1b_reg <= BT_W'(beta) * BT_W'(Q_HI);
        yb_reg  <= 23'(beta) * 23'(R_LO) + 23'(HALF);
        p1_reg  <= p1b_reg;
        y_reg   <= yb_reg;
        qe_reg  <= yq[41:32];
        bt_reg  <= bt_next;
    end

    assign bt = bt_reg;

endmodule

>>> dv/tatc_checker.sv
// checker that predicts and compares the thermistor converter output beats
`timescale 1ns / 1ps

module tatc_checker
    import tatc_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                     clk,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [BETA_W-1:0]        cfg_data,
    input  logic                     adc_valid,
    input  logic                     adc_stall,
    input  logic [ADC_BITS-1:0]      adc_code,
    input  logic                     temp_valid,
    input  logic                     temp_stall,
    input  logic signed [TEMP_W-1:0] temp_tenths,
    input  logic                     invalid,
    output int                       pending,
    output int                       fail_count
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     inv;
    } temp_beat_t;

    localparam longint unsigned FULL_CODE = (64'd1 << ADC_BITS) - 1;

    temp_beat_t       temp_queue[$];
    logic             celsius_q;
    logic [BETA_W-1:0] beta_q;

    initial
    begin
        celsius_q  = 1'b0;
        beta_q     = BETA_RESET;
        fail_count = 0;
        pending    = 0;
    end

    // log2 in q8.24 by repeated squaring of a q1.30 mantissa
    function automatic longint unsigned log2_fix(longint unsigned n);
        longint unsigned e;
        longint unsigned m;
        longint unsigned frac;
        e    = 0;
        frac = 0;
        while (e < 63 && (n >> (e + 1)) != 0)
            e++;
        if (e > 30)
            e = 30;
        m = (n << (30 - e)) & 64'h7FFF_FFFF;
        for (int i = 0; i < 24; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return (e << 24) | frac;
    endfunction

    // kelvin q.16 to rounded, saturated tenths of a degree
    function automatic logic signed [TEMP_W-1:0] kelvin_to_tenths(longint t, logic celsius);
        longint v;
        longint r;
        v = celsius ? 10 * t - 64'sd179011584 : 18 * t - 64'sd301249331;
        r = (v + 32768) >>> 16;
        if (r < -5000)
            r = -5000;
        if (r > 6000)
            r = 6000;
        return r[TEMP_W-1:0];
    endfunction

    function automatic temp_beat_t beta_temperature(logic [ADC_BITS-1:0] code_in);
        temp_beat_t      res;
        longint unsigned code;
        longint unsigned beta;
        longint          l2;
        longint unsigned mag;
        longint          ln_v;
        longint          bt;
        longint          d;
        longint unsigned q;
        longint          t;
        code = code_in;
        beta = beta_q;
        res.inv = 1'b0;
        if (code == 0 || code == FULL_CODE)
        begin
            res.inv  = 1'b1;
            res.temp = kelvin_to_tenths(0, celsius_q);
        end
        else
        begin
            l2   = longint'(log2_fix(FULL_CODE - code)) - longint'(log2_fix(code));
            mag  = (l2 < 0) ? -l2 : l2;
            ln_v = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
            bt   = (((beta * 20) << 24) + 2981) / 5963;
            if (l2 < 0)
                ln_v = -ln_v;
            d = ln_v + bt;
            if (d == 0)
                res.temp = 14'sd6000;
            else
            begin
                q = (beta << 40) / ((d < 0) ? -d : d);
                if (q > (64'd1 << 40))
                    q = 64'd1 << 40;
                t = q;
                if (d < 0)
                    t = -t;
                res.temp = kelvin_to_tenths(t, celsius_q);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // track register writes, predict accepted codes, check output beats
    always @(posedge clk)
    begin
        temp_beat_t want;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_USE_CELSIUS: celsius_q = cfg_data[0];
                REG_BETA_VALUE:  beta_q    = cfg_data;
                default: ;
            endcase
        end
        if (adc_valid && !adc_stall)
            temp_queue.push_back(beta_temperature(adc_code));
        if (temp_valid && !temp_stall)
        begin
            if (temp_queue.size() == 0)
                report_mismatch("output beat with nothing expected");
            else
            begin
                want = temp_queue.pop_front();
                if (temp_tenths !== want.temp)
                    report_mismatch($sformatf("temp_tenths %0d, expected %0d",
                        temp_tenths, want.temp));
                if (invalid !== want.inv)
                    report_mismatch($sformatf("invalid %0b, expected %0b",
                        invalid, want.inv));
            end
        end
        pending = temp_queue.size();
    end

endmodule

>>> dv/tb_top.sv
// stimulus and verdict for the thermistor adc to temperature converter
`timescale 1ns / 1ps

module tb_top;
    import tatc_pkg::*;

    localparam int ADC_BITS   = 10;
    localparam int LATENCY    = 85;
    localparam int CYCLE_CAP  = 2000000;
    localparam int PER_PHASE  = 226;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [0:0]               cfg_index;
    logic [BETA_W-1:0]        cfg_data;
    logic                     adc_valid;
    logic                     adc_stall;
    logic [ADC_BITS-1:0]      adc_code;
    logic                     temp_valid;
    logic                     temp_stall;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic                     invalid;
    int                       pending;
    int                       fail_count;
    int                       cycles;
    logic                     calm;

    thermistor_adc_to_temperature_top #(.ADC_BITS(ADC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .adc_valid(adc_valid), .adc_stall(adc_stall),
        .adc_code(adc_code), .temp_valid(temp_valid), .temp_stall(temp_stall),
        .temp_tenths(temp_tenths), .invalid(invalid)
    );

    tatc_checker #(.ADC_BITS(ADC_BITS)) chk (
        .clk(clk), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .adc_valid(adc_valid), .adc_stall(adc_stall), .adc_code(adc_code),
        .temp_valid(temp_valid), .temp_stall(temp_stall),
        .temp_tenths(temp_tenths), .invalid(invalid),
        .pending(pending), .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // watchdog
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("thermistor_adc_to_temperature_top test failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        temp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                temp_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                temp_stall = 1'b0;
            end
        end
    end

    // one beat on the input channel, then maybe a gap
    task automatic send_code(logic [ADC_BITS-1:0] code);
        adc_code  = code;
        adc_valid = 1'b1;
        @(posedge clk);
        while (adc_stall)
            @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            adc_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic drain;
        adc_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(tatc_reg_t idx, logic [BETA_W-1:0] val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (5) @(negedge clk);
    endtask

    task automatic random_codes(int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_code(ADC_BITS'($urandom_range(0, 3)));
                1: send_code(ADC_BITS'($urandom_range(1019, 1023)));
                default: send_code(ADC_BITS'($urandom_range(0, 1023)));
            endcase
        end
    endtask

    logic [BETA_W-1:0] beta_set[7];
    logic              scale_set[7];

    initial
    begin
        calm      = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_USE_CELSIUS;
        cfg_data  = '0;
        adc_valid = 1'b0;
        adc_code  = '0;
        beta_set  = '{14'd4275, 14'd1000, 14'd10000, 14'd16383, 14'd0, 14'd3950, 14'd1};
        scale_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        // directed codes at reset settings, then in celsius: extremes and midscale
        send_code(10'd0);
        send_code(10'd1023);
        send_code(10'd1);
        send_code(10'd1022);
        send_code(10'd2);
        send_code(10'd511);
        send_code(10'd512);
        send_code(10'd341);
        send_code(10'd682);
        send_code(10'h2AA);
        send_code(10'h155);
        write_reg(REG_USE_CELSIUS, 14'd1);
        send_code(10'd0);
        send_code(10'd1023);
        send_code(10'd1);
        send_code(10'd1022);
        send_code(10'd511);
        // small beta drives the denominator negative near full scale
        write_reg(REG_BETA_VALUE, 14'd1000);
        send_code(10'd1022);
        send_code(10'd1000);
        send_code(10'd5);

        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_USE_CELSIUS, {13'd0, scale_set[p]});
            write_reg(REG_BETA_VALUE, beta_set[p]);
            if (p == 6)
                calm = 1'b1;
            random_codes(PER_PHASE);
        end
        drain();

        if (fail_count == 0)
            $display("thermistor_adc_to_temperature_top test passed");
        else
            $display("thermistor_adc_to_temperature_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tatc_pkg.sv
rtl/tatc_log_cell.sv
rtl/tatc_div_cell.sv
rtl/tatc_beta_recip.sv
rtl/thermistor_adc_to_temperature_top.sv
dv/tatc_checker.sv
dv/tb_top.sv
